@@ hw/rtl/rhmq_pkg.sv @@
package rhmq_pkg;
   localparam int Capacity    = 1024;
   localparam int ValueBits   = 31;
   localparam int BucketCount = 32;
   localparam int AddrBits    = $clog2(Capacity);
   localparam int CountBits   = $clog2(Capacity + 1);
   localparam int TagBits     = $clog2(BucketCount);

   typedef logic [ValueBits-1:0] value_type;
   typedef logic [TagBits-1:0]   tag_type;
   typedef logic [CountBits-1:0] count_type;
   typedef logic [AddrBits-1:0]  addr_type;

   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_BELOW = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      value_type  min_value;
      logic [1:0] status;
      count_type  occupancy;
   } rsp_type;

   function automatic tag_type bucket_of(input value_type x);
      tag_type len;
      len = '0;
      for (int i = 0; i < ValueBits; i++) begin
         if (x[i]) begin
            if (i + 1 > BucketCount - 1) len = tag_type'(BucketCount - 1);
            else len = tag_type'(i + 1);
         end
      end
      return len;
   endfunction
endpackage

@@ hw/rtl/rhmq_if.sv @@
interface rhmq_req_if;
   import rhmq_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   value_type  value;
   modport source (output valid, command, value, input ready);
   modport sink (input valid, command, value, output ready);
endinterface

interface rhmq_rsp_if;
   import rhmq_pkg::*;
   logic       valid;
   logic       ready;
   value_type  min_value;
   logic [1:0] status;
   count_type  occupancy;
   modport source (output valid, min_value, status, occupancy, input ready);
   modport sink (input valid, min_value, status, occupancy, output ready);
endinterface

@@ hw/rtl/radix_heap_monotone_min_queue.sv @@
// Radix-heap min queue. Push, pop and peek transactions enter one at a time.
// Push, refused, unused-code and empty commands are answered directly from
// idle; peek with bucket 0 non-empty answers through the done state.
// Pop with bucket 0 non-empty scans the entry memory one entry at a time up to
// the first bucket-0 entry, then moves the last entry into the hole. When
// bucket 0 is empty a relocation first steps through the buckets (up to 31)
// and then sweeps the memory twice (minimum search, then retag) before the
// result. Entry memory has one write port and one read port, read data
// registered. A result waits in an output register until rsp.ready, and no
// new transaction is accepted while it waits.
module radix_heap_monotone_min_queue import rhmq_pkg::*; (
   input logic         clock,
   input logic         reset,
   rhmq_req_if.sink    req,
   rhmq_rsp_if.source  rsp
);
   localparam logic [3:0] S_IDLE = 4'd0, S_FIND = 4'd1, S_MINRD = 4'd2,
                          S_MINCK = 4'd3, S_RTRD = 4'd4, S_RTCK = 4'd5,
                          S_POPRD = 4'd6, S_POPCK = 4'd7, S_LASTRD = 4'd8,
                          S_LASTWR = 4'd9, S_DONE = 4'd10;

   value_type mem_val [Capacity];
   tag_type   mem_tag [Capacity];
   value_type rd_val_ff;
   tag_type   rd_tag_ff;
   logic      we;
   addr_type  waddr, raddr;
   value_type wval;
   tag_type   wtag;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_val[waddr] <= wval;
         mem_tag[waddr] <= wtag;
      end
      rd_val_ff <= mem_val[raddr];
      rd_tag_ff <= mem_tag[raddr];
   end

   logic [3:0] state_ff, state_in;
   count_type  fill_ff [BucketCount];
   value_type  last_ff, last_in;
   count_type  total_ff, total_in;
   count_type  idx_ff, idx_in;
   tag_type    bkt_ff, bkt_in;
   value_type  best_ff, best_in;
   logic       found_ff, found_in;
   logic [1:0] cmd_ff, cmd_in;
   addr_type   hole_ff, hole_in;
   logic       out_v_ff, out_v_in;
   rsp_type    out_ff, out_in;
   logic       fill_inc, fill_dec0, fill_clr;
   tag_type    inc_tag;
   tag_type   ntag;

   assign req.ready     = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp.valid     = out_v_ff;
   assign rsp.min_value = out_ff.min_value;
   assign rsp.status    = out_ff.status;
   assign rsp.occupancy = out_ff.occupancy;
   assign ntag = bucket_of(rd_val_ff ^ best_ff);

   always_comb begin
      state_in = state_ff; last_in = last_ff; total_in = total_ff;
      idx_in = idx_ff; bkt_in = bkt_ff; best_in = best_ff; found_in = found_ff;
      cmd_in = cmd_ff; hole_in = hole_ff; out_v_in = out_v_ff; out_in = out_ff;
      we = 1'b0; waddr = total_ff[AddrBits-1:0]; raddr = idx_ff[AddrBits-1:0];
      wval = req.value; wtag = bucket_of(req.value ^ last_ff);
      fill_inc = 1'b0; fill_dec0 = 1'b0; fill_clr = 1'b0; inc_tag = wtag;
      if (out_v_ff && rsp.ready) out_v_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && !out_v_ff) begin
               cmd_in = req.command;
               out_in = '{min_value: '0, status: ST_OK, occupancy: total_ff};
               case (req.command)
                  CMD_PUSH: begin
                     if (req.value < last_ff) out_in.status = ST_BELOW;
                     else if (total_ff >= count_type'(Capacity))
                        out_in.status = ST_FULL;
                     else begin
                        we = 1'b1; fill_inc = 1'b1;
                        total_in = total_ff + 1'b1;
                        out_in.occupancy = total_ff + 1'b1;
                     end
                     out_v_in = 1'b1;
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (total_ff == '0) begin
                        out_in.status = ST_EMPTY; out_v_in = 1'b1;
                     end else if (fill_ff[0] != '0) begin
                        idx_in = '0; state_in = S_DONE;
                     end else begin
                        bkt_in = tag_type'(1); state_in = S_FIND;
                     end
                  end
                  default: out_v_in = 1'b1;
               endcase
            end
         end
         S_FIND: begin
            if (fill_ff[bkt_ff] != '0) begin
               idx_in = '0; found_in = 1'b0; state_in = S_MINRD;
            end else if (bkt_ff == tag_type'(BucketCount - 1)) begin
               out_in.status = ST_EMPTY; out_v_in = 1'b1; state_in = S_IDLE;
            end else bkt_in = bkt_ff + 1'b1;
         end
         S_MINRD: begin
            if (idx_ff >= total_ff) begin
               idx_in = '0; state_in = S_RTRD;
            end else state_in = S_MINCK;
         end
         S_MINCK: begin
            if (rd_tag_ff == bkt_ff && (!found_ff || rd_val_ff < best_ff)) begin
               best_in = rd_val_ff; found_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1; state_in = S_MINRD;
         end
         S_RTRD: begin
            if (idx_ff >= total_ff) begin
               fill_clr = 1'b1; last_in = best_ff; idx_in = '0;
               state_in = S_DONE;
            end else state_in = S_RTCK;
         end
         S_RTCK: begin
            if (rd_tag_ff == bkt_ff) begin
               we = 1'b1; waddr = idx_ff[AddrBits-1:0];
               wval = rd_val_ff; wtag = ntag; fill_inc = 1'b1; inc_tag = ntag;
            end
            idx_in = idx_ff + 1'b1; state_in = S_RTRD;
         end
         S_DONE: begin
            out_in.min_value = last_ff;
            if (cmd_ff == CMD_POP) begin
               idx_in = '0; state_in = S_POPRD;
            end else begin
               out_v_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_POPRD: state_in = S_POPCK;
         S_POPCK: begin
            if (rd_tag_ff == '0) begin
               hole_in = idx_ff[AddrBits-1:0];
               idx_in = total_ff - 1'b1; state_in = S_LASTRD;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = S_POPRD;
            end
         end
         S_LASTRD: state_in = S_LASTWR;
         S_LASTWR: begin
            we = 1'b1; waddr = hole_ff; wval = rd_val_ff; wtag = rd_tag_ff;
            fill_dec0 = 1'b1; total_in = total_ff - 1'b1;
            out_in.occupancy = total_ff - 1'b1;
            out_v_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; last_ff <= '0; total_ff <= '0; out_v_ff <= 1'b0;
         for (int b = 0; b < BucketCount; b++) fill_ff[b] <= '0;
      end else begin
         state_ff <= state_in; last_ff <= last_in; total_ff <= total_in;
         out_v_ff <= out_v_in;
         for (int b = 0; b < BucketCount; b++) begin
            if (fill_clr && tag_type'(b) == bkt_ff) fill_ff[b] <= '0;
            else if (fill_inc && tag_type'(b) == inc_tag) fill_ff[b] <= fill_ff[b] + 1'b1;
            else if (fill_dec0 && b == 0) fill_ff[b] <= fill_ff[b] - 1'b1;
         end
      end
      idx_ff <= idx_in; bkt_ff <= bkt_in; best_ff <= best_in; found_ff <= found_in;
      cmd_ff <= cmd_in; hole_ff <= hole_in; out_ff <= out_in;
   end
endmodule
